### src/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: shared types and constants for the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int PRI_W   = 32;
   localparam int PAY_W   = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_PUSH_FULL  = 2'd1,
      STATUS_POP_EMPTY  = 2'd2
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic             req_type;
      logic [PRI_W-1:0] priority_req;
      logic [PAY_W-1:0] payload;
   } req_txn_type;

   typedef struct packed {
      logic [PAY_W-1:0]   out_payload;
      logic [PRI_W-1:0]   out_priority;
      logic [1:0]         status;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
   } rsp_txn_type;

   typedef struct packed {
      logic             valid;
      logic [PRI_W-1:0] pri;
      logic [PAY_W-1:0] pay;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [PRI_W-1:0] pri;
      logic [PAY_W-1:0] pay;
   } cell_cmd_type;

endpackage

### src/spq_cell.sv
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted chain; compares against the broadcast
// priority and shifts with its neighbours. Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_cell,
   input  spq_pkg::cell_cmd_type cmd,
   input  spq_pkg::entry_type    left_entry,
   input  logic                  left_open,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output logic                  open
);

   spq_pkg::entry_type entry_ff, entry_in;
   logic               ge;

   // head takes the new entry when it is empty or on strictly smaller priority
   assign ge   = head_cell ? (cmd.pri < entry_ff.pri) : !(entry_ff.pri < cmd.pri);
   assign open = !entry_ff.valid || ge;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push && open) begin
         if (left_open) begin
            entry_in = left_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.pri   = cmd.pri;
            entry_in.pay   = cmd.pay;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.pri <= entry_in.pri;
      entry_ff.pay <= entry_in.pay;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

### src/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority.
// The result strobe comes in the cycle after the transaction is taken.
// Throughput: one transaction per cycle; busy stays low, every cell compares
// and shifts in the same cycle. Synchronous reset empties the queue.
// The receiver cannot stall; results are single-cycle strobes.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spq_pkg::req_txn_type req_data,
   output logic                 rsp_valid,
   output spq_pkg::rsp_txn_type rsp_data
);

   spq_pkg::entry_type    entries [spq_pkg::DEPTH];
   logic                  opens   [spq_pkg::DEPTH];
   spq_pkg::cell_cmd_type cmd;
   spq_pkg::entry_type    empty_entry;
   spq_pkg::rsp_txn_type  rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic [spq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                  accept, is_pop, full, empty, ok;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_pop = (req_data.req_type == spq_pkg::OP_POP);
   assign full   = (count_ff == spq_pkg::COUNT_W'(spq_pkg::DEPTH));
   assign empty  = (count_ff == '0);
   assign ok     = is_pop ? !empty : !full;

   assign cmd.push = accept && !is_pop && ok;
   assign cmd.pop  = accept && is_pop && ok;
   assign cmd.pri  = req_data.priority_req;
   assign cmd.pay  = req_data.payload;

   assign empty_entry = '0;

   genvar g;
   generate
      for (g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .head_cell   (g == 0),
            .cmd         (cmd),
            .left_entry  ((g == 0) ? empty_entry : entries[(g == 0) ? 0 : g - 1]),
            .left_open   ((g == 0) ? 1'b0 : opens[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == spq_pkg::DEPTH - 1) ? empty_entry :
                          entries[(g == spq_pkg::DEPTH - 1) ? g : g + 1]),
            .entry       (entries[g]),
            .open        (opens[g])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
      rsp_in = '0;
      if (cmd.pop) begin
         rsp_in.out_payload  = entries[0].pay;
         rsp_in.out_priority = entries[0].pri;
      end
      if (!ok) begin
         rsp_in.status = is_pop ? spq_pkg::STATUS_POP_EMPTY : spq_pkg::STATUS_PUSH_FULL;
      end else begin
         rsp_in.status = spq_pkg::STATUS_OK;
      end
      rsp_in.entry_count = count_in;
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/spq_checker.sv
`timescale 1ns / 1ps
// spq_checker: port-level assertions for the sorted priority queue.
// Depends on spq_pkg; bound to sorted_priority_queue_top.
module spq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input spq_pkg::rsp_txn_type rsp_data
);

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("no result after accepted transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without transaction");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::STATUS_PUSH_FULL) |->
      (rsp_data.entry_count == spq_pkg::COUNT_W'(spq_pkg::DEPTH)))
      else $error("push rejected while not full");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::STATUS_POP_EMPTY) |->
      (rsp_data.is_empty && rsp_data.out_payload == '0))
      else $error("pop rejected while not empty");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
